// ----- design/mmas_pkg.sv -----
// Shared types and constants for the alarm scheduler.
// No dependencies; imported by every module of the block.
package mmas_pkg;

	localparam int MAX_TIMERS = 8;
	localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CNT_W = $clog2(MAX_TIMERS + 1);

	localparam logic [31:0] WEEK_ORIGIN = 32'd1388966400;
	localparam logic [31:0] WEEK_SECONDS = 32'(7 * 24 * 3600);

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_EVAL = 2'd1;
	localparam logic [1:0] MODE_FIRE = 2'd2;

	localparam logic [1:0] KIND_ONESHOT = 2'd0;
	localparam logic [1:0] KIND_PERIODIC = 2'd1;
	localparam logic [1:0] KIND_WEEKLY = 2'd2;

	localparam logic [1:0] ACT_ON = 2'd0;
	localparam logic [1:0] ACT_OFF = 2'd1;
	localparam logic [1:0] ACT_TOGGLE = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] entry_index;
		logic [1:0] timer_kind;
		logic [31:0] time_value;
		logic [1:0] action_code;
		logic [31:0] now_timestamp;
		logic [3:0] entry_count;
	} cmd_t;

	typedef struct packed {
		logic [31:0] wait_seconds;
		logic [2:0] due_index;
		logic [1:0] due_action;
		logic none_pending;
		logic plug_on;
		logic last;
	} res_t;

	typedef struct packed {
		logic start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] remainder;
	} div_rsp_t;

endpackage

// ----- design/mmas_div.sv -----
// Serial restoring divider, one quotient bit per cycle, remainder only.
// Depends on mmas_pkg.
module mmas_div (
	input logic clk,
	input logic arst_n,
	input mmas_pkg::div_req_t req,
	output mmas_pkg::div_rsp_t rsp
);
	import mmas_pkg::*;

	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [31:0] rem_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic fits;

	assign trial = {rem_q, dvd_q[31]};
	assign diff = trial - {1'b0, dsr_q};
	assign fits = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- design/multi_mode_alarm_scheduler.sv -----
// Alarm scheduler top level: timer table, sequencer and result register.
// Depends on mmas_pkg and mmas_div.
//
// A write item or an unused mode code leaves the sequencer idle. An evaluate
// item walks the entries in use: a one-shot timer, a periodic timer with a
// zero period or an unused kind gets its wait straight away, while a periodic
// timer with a nonzero period or a weekly timer needs a remainder from the
// shared serial divider (32 steps). When a timer is due, the due timers are
// then collected one entry at a time, stretched by any stall on the result
// side. A fire item first walks the entries in use to apply the actions of
// the due timers, then evaluates. cmd_stall stays high until the last result
// has been loaded into the output register; that register lets the next item
// in while it waits.
module multi_mode_alarm_scheduler (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input mmas_pkg::cmd_t cmd,
	output logic res_valid,
	input logic res_stall,
	output mmas_pkg::res_t res
);
	import mmas_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIRE = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_DIVW = 3'd3;
	localparam logic [2:0] ST_MASK = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_NONE = 3'd6;

	logic [2:0] state_q;
	logic [1:0] kind_q [MAX_TIMERS];
	logic [31:0] value_q [MAX_TIMERS];
	logic [1:0] action_q [MAX_TIMERS];
	logic [31:0] wait_q [MAX_TIMERS];
	logic [MAX_TIMERS-1:0] mask_q;
	logic [31:0] tb_q;
	logic [31:0] min_q;
	logic found_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic plug_q;
	logic res_valid_q;
	res_t res_q;

	logic [IDX_W-1:0] idx_s;
	logic accept;
	logic out_free;
	logic at_end;
	logic [31:0] cur_v;
	logic [1:0] cur_k;
	logic [1:0] cur_a;
	logic store_en;
	logic [31:0] store_w;
	logic store_counts;
	logic later;
	logic [MAX_TIMERS-1:0] new_mask;
	div_req_t div_req;
	div_rsp_t div_rsp;

	mmas_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.req (div_req),
		.rsp (div_rsp)
	);

	assign idx_s = idx_q[IDX_W-1:0];
	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign out_free = !res_valid_q || !res_stall;
	assign at_end = (idx_q == count_q);
	assign cur_v = value_q[idx_s];
	assign cur_k = kind_q[idx_s];
	assign cur_a = action_q[idx_s];

	// wait for the current entry, either straight away or from the divider
	always_comb begin
		store_en = 1'b0;
		store_w = '0;
		div_req.start = 1'b0;
		div_req.dividend = tb_q;
		div_req.divisor = cur_v;
		if (state_q == ST_CALC && !at_end) begin
			case (cur_k)
				KIND_ONESHOT: begin
					store_en = 1'b1;
					store_w = cur_v - tb_q;
				end
				KIND_PERIODIC: begin
					if (cur_v == '0) begin
						store_en = 1'b1;
					end else begin
						div_req.start = 1'b1;
					end
				end
				KIND_WEEKLY: begin
					div_req.start = 1'b1;
					div_req.dividend = tb_q - WEEK_ORIGIN;
					div_req.divisor = WEEK_SECONDS;
				end
				default: begin
					store_en = 1'b1;
				end
			endcase
		end else if (state_q == ST_DIVW && div_rsp.done) begin
			store_en = 1'b1;
			if (cur_k == KIND_PERIODIC) begin
				store_w = cur_v - div_rsp.remainder;
			end else if (cur_v > div_rsp.remainder) begin
				store_w = cur_v - div_rsp.remainder;
			end else begin
				store_w = WEEK_SECONDS - div_rsp.remainder + cur_v;
			end
		end
	end

	assign store_counts = (store_w != '0) && !store_w[31];

	always_comb begin
		later = 1'b0;
		for (int j = 0; j < MAX_TIMERS; j++) begin
			if (j > int'(idx_s) && mask_q[j]) begin
				later = 1'b1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_TIMERS; j++) begin
			new_mask[j] = found_q && (j < int'(count_q)) && (wait_q[j] == min_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q <= '0;
			tb_q <= '0;
			min_q <= '0;
			found_q <= 1'b0;
			count_q <= '0;
			idx_q <= '0;
			plug_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (cmd.mode == MODE_EVAL) begin
							tb_q <= cmd.now_timestamp;
							count_q <= (32'(cmd.entry_count) > MAX_TIMERS) ?
								CNT_W'(MAX_TIMERS) : CNT_W'(cmd.entry_count);
							min_q <= '0;
							found_q <= 1'b0;
							state_q <= ST_CALC;
						end else if (cmd.mode == MODE_FIRE) begin
							state_q <= ST_FIRE;
						end
					end
				end
				ST_FIRE: begin
					if (at_end) begin
						tb_q <= tb_q + min_q;
						min_q <= '0;
						found_q <= 1'b0;
						idx_q <= '0;
						state_q <= ST_CALC;
					end else begin
						if (mask_q[idx_s]) begin
							case (cur_a)
								ACT_ON: plug_q <= 1'b1;
								ACT_OFF: plug_q <= 1'b0;
								ACT_TOGGLE: plug_q <= !plug_q;
								default: plug_q <= plug_q;
							endcase
						end
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_CALC: begin
					if (at_end) begin
						state_q <= ST_MASK;
					end else if (div_req.start) begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						state_q <= ST_CALC;
					end
				end
				ST_MASK: begin
					mask_q <= new_mask;
					idx_q <= '0;
					state_q <= found_q ? ST_EMIT : ST_NONE;
				end
				ST_EMIT: begin
					if (at_end) begin
						state_q <= ST_IDLE;
					end else if (!mask_q[idx_s]) begin
						idx_q <= idx_q + CNT_W'(1);
					end else if (out_free) begin
						res_valid_q <= 1'b1;
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_NONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (store_en) begin
				idx_q <= idx_q + CNT_W'(1);
				if (store_counts && (!found_q || store_w < min_q)) begin
					min_q <= store_w;
					found_q <= 1'b1;
				end
			end
		end
	end

	// table, wait store and result payload
	always_ff @(posedge clk) begin
		if (accept && cmd.mode == MODE_WRITE && 32'(cmd.entry_index) < MAX_TIMERS) begin
			kind_q[IDX_W'(cmd.entry_index)] <= cmd.timer_kind;
			value_q[IDX_W'(cmd.entry_index)] <= cmd.time_value;
			action_q[IDX_W'(cmd.entry_index)] <= cmd.action_code;
		end
		if (store_en) begin
			wait_q[idx_s] <= store_w;
		end
		if (state_q == ST_EMIT && !at_end && mask_q[idx_s] && out_free) begin
			res_q.wait_seconds <= min_q;
			res_q.due_index <= 3'(idx_s);
			res_q.due_action <= cur_a;
			res_q.none_pending <= 1'b0;
			res_q.plug_on <= plug_q;
			res_q.last <= !later;
		end else if (state_q == ST_NONE && out_free) begin
			res_q.wait_seconds <= '0;
			res_q.due_index <= '0;
			res_q.due_action <= '0;
			res_q.none_pending <= 1'b1;
			res_q.plug_on <= plug_q;
			res_q.last <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_divw_has_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVW |-> div_rsp.busy || div_rsp.done)
		else $error("waiting on divider that is idle");

	a_min_positive: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> min_q != '0 && !min_q[31])
		else $error("smallest wait is not positive");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.none_pending |-> res_q.last && res_q.wait_seconds == '0)
		else $error("empty result not marked final");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_TIMERS && idx_q <= count_q)
		else $error("entry index beyond count");

endmodule

// ----- tb/multi_mode_alarm_scheduler_tb.sv -----
// Testbench for the alarm scheduler: directed and random items, with a built-in
// predictor of the timer table and plug state checked against every result.
// Depends on mmas_pkg and the multi_mode_alarm_scheduler RTL.
module multi_mode_alarm_scheduler_tb;
	import mmas_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] ACT_NONE = 2'd3;

	localparam int ITEM_TARGET = 410;
	localparam int QUIET_ITEMS = 60;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int TAIL_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	multi_mode_alarm_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	// stimulus backlog; a set drain flag holds that item back until all reports are in
	cmd_t cmd_backlog[$];
	bit drain_first[$];
	bit drain_next = 1'b0;
	logic [MAX_TIMERS-1:0] filled = '0;
	int stim_n = 0;

	// predicted scheduler state
	logic [1:0] slot_kind[MAX_TIMERS];
	logic [31:0] slot_value[MAX_TIMERS];
	logic [1:0] slot_action[MAX_TIMERS];
	logic [31:0] slot_wait[MAX_TIMERS];
	logic [MAX_TIMERS-1:0] due_mask = '0;
	logic [31:0] clock_base = '0;
	logic [31:0] next_wait = '0;
	int slots_in_use = 0;
	logic plug_expected = 1'b0;
	res_t due_reports[$];

	int errors = 0;
	int items_taken = 0;
	int results_seen = 0;
	int idle_evals = 0;
	int tied_evals = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int stall_left = 0;

	initial forever #5 clk = ~clk;

	function automatic logic [31:0] slot_delay(int i);
		logic [31:0] v;
		logic [31:0] m;
		v = slot_value[i];
		case (slot_kind[i])
			KIND_ONESHOT: return v - clock_base;
			KIND_PERIODIC: return (v == 32'd0) ? 32'd0 : v - (clock_base % v);
			KIND_WEEKLY: begin
				m = (clock_base - WEEK_ORIGIN) % WEEK_SECONDS;
				return (v > m) ? v - m : WEEK_SECONDS - m + v;
			end
			default: return 32'd0;
		endcase
	endfunction

	// work out every wait, the smallest positive one and the timers due at it
	task automatic rescan_timers();
		logic found;
		logic [31:0] w;
		int n_due;
		int k;
		res_t r;
		found = 1'b0;
		next_wait = 32'd0;
		due_mask = '0;
		for (int i = 0; i < MAX_TIMERS; i++)
			slot_wait[i] = (i < slots_in_use) ? slot_delay(i) : 32'd0;
		for (int i = 0; i < slots_in_use; i++) begin
			w = slot_wait[i];
			if (w != 32'd0 && !w[31] && (!found || w < next_wait)) begin
				next_wait = w;
				found = 1'b1;
			end
		end
		if (!found) begin
			r = '0;
			r.none_pending = 1'b1;
			r.plug_on = plug_expected;
			r.last = 1'b1;
			due_reports.push_back(r);
			idle_evals++;
		end else begin
			for (int i = 0; i < slots_in_use; i++)
				if (slot_wait[i] == next_wait)
					due_mask[i] = 1'b1;
			n_due = $countones(due_mask);
			if (n_due > 1)
				tied_evals++;
			k = 0;
			for (int i = 0; i < slots_in_use; i++) begin
				if (due_mask[i]) begin
					r.wait_seconds = next_wait;
					r.due_index = 3'(i);
					r.due_action = slot_action[i];
					r.none_pending = 1'b0;
					r.plug_on = plug_expected;
					r.last = (k == n_due - 1);
					due_reports.push_back(r);
					k++;
				end
			end
		end
	endtask

	task automatic apply_item(input cmd_t c);
		case (c.mode)
			MODE_WRITE: begin
				slot_kind[c.entry_index] = c.timer_kind;
				slot_value[c.entry_index] = c.time_value;
				slot_action[c.entry_index] = c.action_code;
			end
			MODE_EVAL: begin
				clock_base = c.now_timestamp;
				slots_in_use = (c.entry_count > 4'(MAX_TIMERS)) ? MAX_TIMERS
					: int'(c.entry_count);
				rescan_timers();
			end
			MODE_FIRE: begin
				for (int i = 0; i < slots_in_use; i++) begin
					if (due_mask[i]) begin
						case (slot_action[i])
							ACT_ON: plug_expected = 1'b1;
							ACT_OFF: plug_expected = 1'b0;
							ACT_TOGGLE: plug_expected = ~plug_expected;
							default: ;
						endcase
					end
				end
				clock_base = clock_base + next_wait;
				rescan_timers();
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.mode = 2'($urandom_range(0, 3));
		c.entry_index = 3'($urandom_range(0, 7));
		c.timer_kind = 2'($urandom_range(0, 3));
		c.time_value = $urandom;
		c.action_code = 2'($urandom_range(0, 3));
		c.now_timestamp = $urandom;
		c.entry_count = 4'($urandom_range(0, 15));
		return c;
	endfunction

	task automatic queue_item(input cmd_t c);
		cmd_backlog.push_back(c);
		drain_first.push_back(drain_next);
		drain_next = 1'b0;
		if (c.mode != MODE_UNUSED)
			stim_n++;
	endtask

	task automatic queue_write(input int slot, input logic [1:0] kind,
			input logic [31:0] val, input logic [1:0] act);
		cmd_t c;
		c = noise_cmd();
		c.mode = MODE_WRITE;
		c.entry_index = 3'(slot);
		c.timer_kind = kind;
		c.time_value = val;
		c.action_code = act;
		filled[slot] = 1'b1;
		queue_item(c);
	endtask

	task automatic queue_eval(input logic [31:0] now, input logic [3:0] cnt);
		cmd_t c;
		c = noise_cmd();
		c.mode = MODE_EVAL;
		c.now_timestamp = now;
		c.entry_count = cnt;
		queue_item(c);
	endtask

	task automatic queue_fire();
		cmd_t c;
		c = noise_cmd();
		c.mode = MODE_FIRE;
		queue_item(c);
	endtask

	task automatic queue_ignored();
		cmd_t c;
		c = noise_cmd();
		c.mode = MODE_UNUSED;
		queue_item(c);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			send_gap <= 0;
		end else begin : drive
			logic nxt_valid;
			int nxt_gap;
			nxt_valid = cmd_valid;
			nxt_gap = send_gap;
			if (cmd_valid && !cmd_stall) begin
				nxt_valid = 1'b0;
				if (cmd_backlog.size() >= QUIET_ITEMS && $urandom_range(0, 3) == 0)
					nxt_gap = $urandom_range(1, 12);
			end
			if (!nxt_valid) begin
				if (nxt_gap > 0) begin
					nxt_gap--;
				end else if (cmd_backlog.size() != 0 && !(drain_first[0]
						&& (cmd_valid || due_reports.size() != 0))) begin
					cmd <= cmd_backlog.pop_front();
					void'(drain_first.pop_front());
					nxt_valid = 1'b1;
				end
			end
			cmd_valid <= nxt_valid;
			send_gap <= nxt_gap;
		end
	end

	// monitor, checker, result-side stalls and watchdog
	always @(posedge clk) begin
		if (arst_n) begin : observe
			res_t want;
			idle_cycles++;
			if (cmd_valid && !cmd_stall) begin
				apply_item(cmd);
				items_taken++;
				idle_cycles = 0;
			end
			if (res_valid && !res_stall) begin
				idle_cycles = 0;
				results_seen++;
				if (due_reports.size() == 0) begin
					errors++;
					$display("%0t: result expected none, got %p", $time, res);
				end else begin
					want = due_reports.pop_front();
					check_field("wait_seconds", want.wait_seconds, res.wait_seconds);
					check_field("due_index", 32'(want.due_index), 32'(res.due_index));
					check_field("due_action", 32'(want.due_action), 32'(res.due_action));
					check_field("none_pending", 32'(want.none_pending),
						32'(res.none_pending));
					check_field("plug_on", 32'(want.plug_on), 32'(res.plug_on));
					check_field("last", 32'(want.last), 32'(res.last));
				end
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
				if (cmd_backlog.size() >= QUIET_ITEMS && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 12);
			end
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("%0t: nothing moved for %0d cycles", $time, idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : main
		logic [31:0] base;
		logic [31:0] val;
		logic [1:0] kind;
		logic [1:0] act;
		int nw;
		int slot;
		int pick;
		int reach;
		int cnt;

		// directed: empty table, every kind and action, extremes of time and count
		queue_eval(32'd0, 4'd0);
		queue_fire();
		queue_write(0, KIND_ONESHOT, 32'd1000, ACT_ON);
		queue_write(1, KIND_PERIODIC, 32'd0, ACT_OFF);
		queue_write(2, KIND_UNUSED, 32'd500, ACT_TOGGLE);
		queue_write(3, KIND_WEEKLY, 32'hFFFF_FFFF, ACT_TOGGLE);
		queue_write(4, KIND_ONESHOT, 32'hFFFF_FFFF, ACT_NONE);
		queue_write(5, KIND_PERIODIC, 32'hFFFF_FFFF, ACT_OFF);
		queue_write(6, KIND_WEEKLY, 32'd0, ACT_ON);
		queue_write(7, KIND_ONESHOT, 32'd1000, ACT_TOGGLE);
		queue_eval(32'd0, 4'd15);
		queue_fire();
		queue_fire();
		queue_eval(32'hFFFF_FFFF, 4'd8);
		queue_eval(WEEK_ORIGIN, 4'd8);
		queue_ignored();
		// all eight slots due at once
		for (int i = 0; i < MAX_TIMERS; i++)
			queue_write(i, KIND_PERIODIC, 32'd3600, (i % 2 == 0) ? ACT_TOGGLE : ACT_ON);
		queue_eval(32'd100, 4'd8);
		queue_fire();

		// random: write a batch of timers, evaluate near them, then fire a few times
		drain_next = 1'b1;
		while (stim_n < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				drain_next = 1'b1;
			base = $urandom;
			nw = $urandom_range(1, MAX_TIMERS);
			for (int k = 0; k < nw; k++) begin
				slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_TIMERS - 1) : k;
				pick = $urandom_range(0, 19);
				if (pick < 6) begin
					kind = KIND_ONESHOT;
					pick = $urandom_range(0, 9);
					val = (pick < 7) ? base + 32'(60 * $urandom_range(1, 4))
						: (pick < 9) ? $urandom : base - 32'($urandom_range(0, 600));
				end else if (pick < 12) begin
					kind = KIND_PERIODIC;
					pick = $urandom_range(0, 19);
					case (pick % 4)
						0: val = 32'd60;
						1: val = 32'd120;
						2: val = 32'd3600;
						default: val = 32'd86400;
					endcase
					if (pick >= 14)
						val = 32'($urandom_range(1, 1000));
					if (pick == 19)
						val = $urandom;
					if (pick == 18)
						val = 32'd0;
				end else if (pick < 19) begin
					kind = KIND_WEEKLY;
					pick = $urandom_range(0, 9);
					val = (pick < 7) ? 32'(3600 * $urandom_range(0, 167))
						: (pick < 9) ? 32'($urandom_range(0, 604799)) : $urandom;
				end else begin
					kind = KIND_UNUSED;
					val = $urandom;
				end
				pick = $urandom_range(0, 9);
				act = (pick < 3) ? ACT_ON : (pick < 6) ? ACT_OFF
					: (pick < 9) ? ACT_TOGGLE : ACT_NONE;
				queue_write(slot, kind, val, act);
			end
			// never evaluate past a slot that has not been written
			reach = 0;
			while (reach < MAX_TIMERS && filled[reach])
				reach++;
			if (reach == MAX_TIMERS && $urandom_range(0, 4) == 0)
				cnt = $urandom_range(9, 15);
			else if ($urandom_range(0, 3) == 0)
				cnt = $urandom_range(0, reach);
			else
				cnt = reach;
			queue_eval(($urandom_range(0, 4) == 0) ? $urandom : base, 4'(cnt));
			repeat ($urandom_range(1, 6))
				queue_fire();
			if ($urandom_range(0, 9) == 0)
				queue_ignored();
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || cmd_valid || due_reports.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items and checked %0d reports: %0d scans with nothing pending,",
			items_taken, results_seen, idle_evals);
		$display("%0d scans with several timers due together.", tied_evals);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
